FILE: rtl/pcs_pkg.sv
`timescale 1ns / 1ps
package pcs_pkg;

    localparam int PCS_MAX_ITEMS = 1024;

    localparam int RATING_W = 3;
    localparam int MEAN_W   = 16;
    localparam int SIM_W    = 16;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int WIDE_W  = 128;
    localparam int MPLR_W  = 64;
    localparam int FRAC_SH = 30;

    localparam logic [MEAN_W-1:0] MEAN_RESET = 16'd24576;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_B = 1'd1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_VAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_P,
        ST_MUL_N,
        ST_CMP,
        ST_SQ,
        ST_TSTART,
        ST_TMUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic acc_en;
        logic start_p;
        logic start_n;
        logic start_t;
        logic save_p;
        logic save_r;
        logic set_full;
        logic init_bits;
        logic sq_en;
        logic q_try;
        logic bit_dec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic zero_var;
        logic busy;
        logic le_p;
        logic le_t;
        logic bit_zero;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/pcs_item_if.sv
`timescale 1ns / 1ps
interface pcs_item_if;
    import pcs_pkg::*;
    logic                valid;
    logic                ready;
    logic [RATING_W-1:0] rating_a;
    logic [RATING_W-1:0] rating_b;
    logic                last_item;

    modport source (output valid, rating_a, rating_b, last_item, input ready);
    modport sink   (input valid, rating_a, rating_b, last_item, output ready);
endinterface

FILE: rtl/pcs_result_if.sv
`timescale 1ns / 1ps
interface pcs_result_if;
    import pcs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SIM_W-1:0]    similarity;
    logic        [COUNT_W-1:0]  corated_count;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, similarity, corated_count, status, input ready);
    modport sink   (input valid, similarity, corated_count, status, output ready);
endinterface

FILE: rtl/pcs_ctrl.sv
`timescale 1ns / 1ps
module pcs_ctrl
    import pcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_last_item,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   w_take;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_take     = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && i_last_item) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.few || i_stat.zero_var) n_state = ST_DONE;
                else n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                if (!i_stat.busy) n_state = ST_MUL_N;
            end
            ST_MUL_N: begin
                if (!i_stat.busy) n_state = ST_CMP;
            end
            ST_CMP: begin
                if (i_stat.le_p) n_state = ST_DONE;
                else n_state = ST_SQ;
            end
            ST_SQ:     n_state = ST_TSTART;
            ST_TSTART: n_state = ST_TMUL;
            ST_TMUL: begin
                if (!i_stat.busy) begin
                    if (i_stat.bit_zero) n_state = ST_DONE;
                    else n_state = ST_SQ;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:   o_cmd.acc_en = w_take;
            ST_EVAL:   o_cmd.start_p = !(i_stat.few || i_stat.zero_var);
            ST_MUL_P: begin
                o_cmd.save_p  = !i_stat.busy;
                o_cmd.start_n = !i_stat.busy;
            end
            ST_MUL_N:  o_cmd.save_r = !i_stat.busy;
            ST_CMP: begin
                o_cmd.set_full  = i_stat.le_p;
                o_cmd.init_bits = !i_stat.le_p;
            end
            ST_SQ:     o_cmd.sq_en = 1'b1;
            ST_TSTART: o_cmd.start_t = 1'b1;
            ST_TMUL: begin
                o_cmd.q_try   = !i_stat.busy;
                o_cmd.bit_dec = !i_stat.busy && !i_stat.bit_zero;
            end
            ST_DONE:   o_cmd.load_out = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/pcs_dpath.sv
`timescale 1ns / 1ps
module pcs_dpath
    import pcs_pkg::*;
#(
    parameter int MAX_ITEMS = PCS_MAX_ITEMS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [RATING_W-1:0]        i_rating_a,
    input  logic [RATING_W-1:0]        i_rating_b,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [SIM_W-1:0]    o_similarity,
    output logic [COUNT_W-1:0]         o_corated_count,
    output logic [STATUS_W-1:0]        o_status,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = 32 + $clog2(MAX_ITEMS);

    logic [MEAN_W-1:0]        r_mean_a, r_mean_b;
    logic signed [SW:0]       r_cross;
    logic [SW-1:0]            r_sqa, r_sqb;
    logic [CW-1:0]            r_cnt;

    logic [WIDE_W-1:0]        r_acc, r_mcand, r_p, r_r;
    logic [MPLR_W-1:0]        r_mplier;
    logic [SIM_W-1:0]         r_q;
    logic [3:0]               r_bit;
    logic [2*(SIM_W-1)-1:0]   r_c2;

    logic                     r_ovalid;
    logic signed [SIM_W-1:0]  r_sim;
    logic [COUNT_W-1:0]       r_ocnt;
    logic [STATUS_W-1:0]      r_ostat;

    logic signed [17:0]       w_da, w_db;
    logic signed [35:0]       w_dab;
    logic [31:0]              w_daa, w_dbb;
    logic                     w_use;
    logic [SW:0]              w_mag;
    logic [SIM_W-1:0]         w_c;
    logic signed [SIM_W-1:0]  w_sim;
    logic [STATUS_W-1:0]      w_stat;

    // Deviations from the means in Q3.13
    assign w_da  = $signed({1'b0, i_rating_a, 13'b0}) - $signed({2'b0, r_mean_a});
    assign w_db  = $signed({1'b0, i_rating_b, 13'b0}) - $signed({2'b0, r_mean_b});
    assign w_dab = w_da * w_db;
    assign w_daa = 32'(w_da * w_da);
    assign w_dbb = 32'(w_db * w_db);
    assign w_use = (i_rating_a != '0) && (i_rating_b != '0) && (r_cnt < CW'(MAX_ITEMS));

    assign w_mag = r_cross[SW] ? (SW+1)'(-r_cross) : (SW+1)'(r_cross);
    assign w_c   = r_q | (SIM_W'(1) << r_bit);

    always_comb begin
        if (r_cnt < CW'(2)) w_stat = STAT_FEW;
        else if (r_sqa == '0 || r_sqb == '0) w_stat = STAT_ZERO_VAR;
        else w_stat = STAT_OK;
    end

    always_comb begin
        if (w_stat != STAT_OK) w_sim = '0;
        else if (r_cross[SW]) w_sim = -$signed(r_q);
        else if (r_q[SIM_W-1]) w_sim = 16'sd32767;
        else w_sim = $signed(r_q);
    end

    assign o_stat.few      = (w_stat == STAT_FEW);
    assign o_stat.zero_var = (w_stat == STAT_ZERO_VAR);
    assign o_stat.busy     = (r_mplier != '0);
    assign o_stat.le_p     = (r_p <= r_r);
    assign o_stat.le_t     = (r_acc <= r_r);
    assign o_stat.bit_zero = (r_bit == '0);
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    // Configuration and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_a <= MEAN_RESET;
            r_mean_b <= MEAN_RESET;
            r_cross  <= '0;
            r_sqa    <= '0;
            r_sqb    <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MEAN_A: r_mean_a <= i_cfg_data;
                    REG_MEAN_B: r_mean_b <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_cross <= '0;
                r_sqa   <= '0;
                r_sqb   <= '0;
                r_cnt   <= '0;
            end else if (i_cmd.acc_en && w_use) begin
                r_cross <= r_cross + (SW+1)'(w_dab);
                r_sqa   <= r_sqa + SW'(w_daa);
                r_sqb   <= r_sqb + SW'(w_dbb);
                r_cnt   <= r_cnt + CW'(1);
            end
        end
    end

    // Shift-add multiplier, one multiplier bit a cycle; wraps at 128 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else if (i_cmd.start_p) begin
            r_acc    <= '0;
            r_mcand  <= WIDE_W'(r_sqa);
            r_mplier <= MPLR_W'(r_sqb);
        end else if (i_cmd.start_n) begin
            r_acc    <= '0;
            r_mcand  <= WIDE_W'(w_mag);
            r_mplier <= MPLR_W'(w_mag);
        end else if (i_cmd.start_t) begin
            r_acc    <= '0;
            r_mcand  <= r_p;
            r_mplier <= MPLR_W'(r_c2);
        end else if (r_mplier != '0) begin
            if (r_mplier[0]) r_acc <= r_acc + r_mcand;
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    // Bitwise search for the largest quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_p) r_p <= r_acc;
        if (i_cmd.save_r) r_r <= r_acc << FRAC_SH;
        if (i_cmd.sq_en)  r_c2 <= w_c[SIM_W-2:0] * w_c[SIM_W-2:0];
        if (i_cmd.set_full) begin
            r_q <= SIM_W'(1) << (SIM_W - 1);
        end else if (i_cmd.init_bits) begin
            r_q   <= '0;
            r_bit <= 4'(SIM_W - 2);
        end else begin
            if (i_cmd.q_try && o_stat.le_t) r_q <= w_c;
            if (i_cmd.bit_dec) r_bit <= r_bit - 4'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sim   <= w_sim;
            r_ocnt  <= COUNT_W'(r_cnt);
            r_ostat <= w_stat;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_similarity    = r_sim;
    assign o_corated_count = r_ocnt;
    assign o_status        = r_ostat;

endmodule

FILE: rtl/pearson_corated_similarity.sv
`timescale 1ns / 1ps
// Pearson similarity of two users over the items both have rated. Each
// item carries one rating per user (0 means unrated); co-rated items
// update the cross and square deviation sums against the two mean
// registers (unsigned Q3.13, reset 3.0), up to MAX_ITEMS items.
// The item flagged last_item closes the pair: after it the input stalls
// while a 128-bit shift-add multiplier (one multiplier bit per cycle) forms
// the product of the variance sums and the squared cross sum; unless that
// square, scaled by 2^30, reaches the product (full-scale result), a
// 15-step bit search finds the Q1.15 result, each step one 15x15 square and
// one serial multiply. With fewer than two co-rated items (status 1) or a
// zero variance (status 2) the result is 0 and skips the multiplies. A
// result of +1.0 reads 32767. The result waits in an output register; a new
// pair may stream in meanwhile.
// Write the mean registers only while the block is idle.
module pearson_corated_similarity
    import pcs_pkg::*;
#(
    parameter int MAX_ITEMS = PCS_MAX_ITEMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcs_item_if.sink              i_item,
    pcs_result_if.source          o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_item.ready = w_in_ready;

    // Sequencer: accept items, then step through the closing computation
    pcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_last_item (i_item.last_item),
        .o_in_ready  (w_in_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Sums, serial multiplier, quotient search and output register
    pcs_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_rating_a      (i_item.rating_a),
        .i_rating_b      (i_item.rating_b),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_similarity    (o_result.similarity),
        .o_corated_count (o_result.corated_count),
        .o_status        (o_result.status),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );

endmodule

FILE: rtl/pcs_checker.sv
`timescale 1ns / 1ps
module pcs_checker
    import pcs_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_last_item,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [SIM_W-1:0]   i_similarity,
    input logic [COUNT_W-1:0]        i_corated_count,
    input logic [STATUS_W-1:0]       i_status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Stall the input after the closing item
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_last_item |=> !i_in_ready)
        else $error("input taken during closing computation");

    // Special cases report zero similarity
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STAT_OK |-> i_similarity == '0)
        else $error("nonzero similarity with error status");

    // A good result needs two co-rated items
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_OK |-> i_corated_count >= COUNT_W'(2))
        else $error("ok status with too few items");

endmodule

bind pearson_corated_similarity pcs_checker u_pcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_last_item     (i_item.last_item),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_similarity    (o_result.similarity),
    .i_corated_count (o_result.corated_count),
    .i_status        (o_result.status)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pearson_corated_similarity. A predictor follows each
// accepted item and queues the expected score on the last item of each pair;
// the checker compares every accepted score, field by field, with the oldest
// expected one.
module tb;
    import pcs_pkg::*;

    typedef struct {
        logic signed [SIM_W-1:0]    similarity;
        logic        [COUNT_W-1:0]  corated_count;
        logic        [STATUS_W-1:0] status;
    } t_score;

    // Longest time the block takes to close a pair, with margin.
    localparam int CLOSE_CYCLES = 800;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pcs_item_if   item_ch ();
    pcs_result_if score_ch ();

    pearson_corated_similarity DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_result   (score_ch.source)
    );

    // Predictor state: mean registers and running sums of the open pair.
    logic [MEAN_W-1:0] mean_a_q;
    logic [MEAN_W-1:0] mean_b_q;
    longint            cross_acc;
    longint unsigned   sq_a_acc;
    longint unsigned   sq_b_acc;
    int                corated_acc;

    t_score expected_scores[$];
    int     mismatch_count;
    bit     sender_idles;
    bit     receiver_idles;
    bit     hold_scores;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Largest q below 32768 with q^2 * A * B <= 2^30 * num^2, or 32768 when A * B <= 2^30 * num^2; signed Q1.15.
    function automatic logic signed [SIM_W-1:0] corr_q15(input longint num,
                                                         input longint unsigned sa,
                                                         input longint unsigned sb);
        logic [191:0]    prod_sq;
        logic [191:0]    num_sq;
        logic [191:0]    trial;
        longint unsigned mag;
        int              q;
        int              c;
        mag     = (num < 0) ? longint'(-num) : longint'(num);
        prod_sq = 192'(sa) * 192'(sb);
        num_sq  = (192'(mag) * 192'(mag)) << 30;
        q = 0;
        if (prod_sq <= num_sq) begin
            q = 32768;
        end else begin
            for (int b = 14; b >= 0; b--) begin
                c     = q | (1 << b);
                trial = prod_sq * 192'(c * c);
                if (trial <= num_sq) q = c;
            end
        end
        if (num < 0) return SIM_W'(-q);
        return (q > 32767) ? 16'sd32767 : SIM_W'(q);
    endfunction

    // Advance the predictor by one accepted item.
    task automatic track_item(input logic [2:0] ra, input logic [2:0] rb, input logic last);
        longint da;
        longint db;
        t_score s;
        if (ra != 0 && rb != 0 && corated_acc < PCS_MAX_ITEMS) begin
            da = longint'(ra) * 8192 - longint'(mean_a_q);
            db = longint'(rb) * 8192 - longint'(mean_b_q);
            cross_acc   += da * db;
            sq_a_acc    += longint'(da * da);
            sq_b_acc    += longint'(db * db);
            corated_acc++;
        end
        if (!last) return;
        s.similarity    = '0;
        s.corated_count = COUNT_W'(corated_acc);
        if (corated_acc < 2)
            s.status = STAT_FEW;
        else if (sq_a_acc == 0 || sq_b_acc == 0)
            s.status = STAT_ZERO_VAR;
        else begin
            s.status     = STAT_OK;
            s.similarity = corr_q15(cross_acc, sq_a_acc, sq_b_acc);
        end
        expected_scores.push_back(s);
        cross_acc   = 0;
        sq_a_acc    = 0;
        sq_b_acc    = 0;
        corated_acc = 0;
    endtask

    // Offer one item at a falling edge; hold it until the block takes it.
    task automatic send_item(input logic [2:0] ra, input logic [2:0] rb, input logic last);
        int gap;
        @(negedge i_clk);
        gap = sender_idles ? $urandom_range(9, 0) : 0;
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.rating_a  = ra;
        item_ch.rating_b  = rb;
        item_ch.last_item = last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        track_item(ra, rb, last);
    endtask

    task automatic lower_valid();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
    endtask

    // Wait for every score, then for a pair that closes with no score.
    task automatic drain();
        lower_valid();
        wait (expected_scores.size() == 0);
        repeat (CLOSE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mean(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == REG_MEAN_A) mean_a_q = value;
        else mean_b_q = value;
    endtask

    function automatic logic [2:0] pick_rating();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 8) return 3'd0;
        if (roll < 12) return 3'($urandom_range(7, 6));
        return 3'($urandom_range(5, 1));
    endfunction

    // Well-formed pair of random length with random ratings.
    task automatic send_pair(input int len);
        for (int k = 0; k < len; k++)
            send_item(pick_rating(), pick_rating(), k == len - 1);
    endtask

    // Receiver: draw a stall per score, or hold off a long stretch.
    initial begin
        int gap;
        score_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = hold_scores ? 400 : (receiver_idles ? $urandom_range(9, 0) : 0);
            if (gap > 0) begin
                score_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            score_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!score_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && score_ch.valid && score_ch.ready) begin
            if (expected_scores.size() == 0) begin
                report_mismatch("unexpected score, similarity", score_ch.similarity, 0);
            end else begin
                want = expected_scores.pop_front();
                if (score_ch.similarity !== want.similarity)
                    report_mismatch("similarity", score_ch.similarity, want.similarity);
                if (score_ch.corated_count !== want.corated_count)
                    report_mismatch("corated_count", score_ch.corated_count,
                                    want.corated_count);
                if (score_ch.status !== want.status)
                    report_mismatch("status", score_ch.status, want.status);
            end
        end
    end

    // Extremes of the ratings and each special case, at the reset means.
    task automatic test_directed();
        send_item(3'd0, 3'd4, 1'b1);                // nothing co-rated
        send_item(3'd2, 3'd5, 1'b1);                // only one co-rated
        send_item(3'd3, 3'd1, 1'b0);                // first user at the mean
        send_item(3'd3, 3'd5, 1'b1);
        send_item(3'd1, 3'd1, 1'b0);                // perfect positive
        send_item(3'd5, 3'd5, 1'b1);
        send_item(3'd1, 3'd5, 1'b0);                // perfect negative
        send_item(3'd5, 3'd1, 1'b1);
        send_item(3'd7, 3'd6, 1'b0);                // out-of-range ratings
        send_item(3'd6, 3'd0, 1'b0);
        send_item(3'd1, 3'd7, 1'b0);
        send_item(3'd0, 3'd0, 1'b1);                // unrated last item
        send_item(3'd2, 3'd4, 1'b0);
        send_item(3'd4, 3'd3, 1'b0);
        send_item(3'd5, 3'd2, 1'b0);
        send_item(3'd1, 3'd5, 1'b1);
        drain();
    endtask

    // Mean registers at their extremes, including all bits set.
    task automatic test_mean_extremes();
        write_mean(REG_MEAN_A, 16'd0);
        write_mean(REG_MEAN_B, 16'hFFFF);
        send_item(3'd7, 3'd7, 1'b0);
        send_item(3'd1, 3'd2, 1'b0);
        send_item(3'd4, 3'd6, 1'b1);
        drain();
        write_mean(REG_MEAN_A, 16'd40960);
        write_mean(REG_MEAN_B, 16'd0);
        send_item(3'd5, 3'd1, 1'b0);
        send_item(3'd2, 3'd7, 1'b0);
        send_item(3'd3, 3'd3, 1'b1);
        drain();
        write_mean(REG_MEAN_A, 16'd8192);
        write_mean(REG_MEAN_B, 16'd40960);
        send_item(3'd1, 3'd5, 1'b0);                // first user's variance is zero
        send_item(3'd1, 3'd2, 1'b1);
        drain();
    endtask

    // Push past the co-rated limit in one pair: extra items are dropped.
    task automatic test_corated_limit();
        write_mean(REG_MEAN_A, MEAN_RESET);
        write_mean(REG_MEAN_B, 16'd20000);
        for (int k = 0; k < PCS_MAX_ITEMS + 6; k++)
            send_item(3'($urandom_range(5, 1)), 3'($urandom_range(7, 1)),
                      k == PCS_MAX_ITEMS + 5);
        drain();
    endtask

    // Hold the receiver off while short pairs keep coming, then pause the
    // sender until every score is back.
    task automatic test_backpressure();
        hold_scores = 1'b1;
        for (int p = 0; p < 8; p++) send_pair($urandom_range(3, 1));
        hold_scores = 1'b0;
        lower_valid();
        wait (expected_scores.size() == 0);
        for (int p = 0; p < 4; p++) send_pair($urandom_range(4, 2));
        drain();
    endtask

    // Random pairs over several mean settings; idling on and off by phase.
    task automatic test_random();
        int sent;
        for (int phase = 0; phase < 6; phase++) begin
            write_mean(REG_MEAN_A, (phase == 5) ? 16'd24576 : 16'($urandom_range(40960, 0)));
            write_mean(REG_MEAN_B, (phase == 5) ? 16'd0 : 16'($urandom_range(65535, 0)));
            sender_idles   = phase[0];
            receiver_idles = phase != 2;
            sent = 0;
            while (sent < 110) begin
                int len;
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 1)
                                                  : $urandom_range(24, 2);
                send_pair(len);
                sent += len;
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_MEAN_A;
        i_cfg_data         = '0;
        item_ch.valid      = 1'b0;
        item_ch.rating_a   = '0;
        item_ch.rating_b   = '0;
        item_ch.last_item  = 1'b0;
        mean_a_q           = MEAN_RESET;
        mean_b_q           = MEAN_RESET;
        cross_acc          = 0;
        sq_a_acc           = 0;
        sq_b_acc           = 0;
        corated_acc        = 0;
        mismatch_count     = 0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        hold_scores        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_mean_extremes();
        test_corated_limit();
        test_backpressure();
        test_random();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pcs_pkg.sv
rtl/pcs_item_if.sv
rtl/pcs_result_if.sv
rtl/pcs_ctrl.sv
rtl/pcs_dpath.sv
rtl/pearson_corated_similarity.sv
rtl/pcs_checker.sv
tb/sv/tb.sv
